// ----- rtl/nrmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_pkg
// Shared types, character codes and field kinds of the RMC field extractor.
// ----------------------------------------------------------------------------
package nrmc_pkg;

   typedef logic [2:0] kind_type;

   localparam kind_type KIND_TIME   = 3'd0;
   localparam kind_type KIND_STATUS = 3'd1;
   localparam kind_type KIND_LAT    = 3'd2;
   localparam kind_type KIND_LON    = 3'd3;
   localparam kind_type KIND_SPEED  = 3'd4;
   localparam kind_type KIND_DATE   = 3'd5;
   localparam kind_type KIND_END    = 3'd6;
   localparam kind_type KIND_ABORT  = 3'd7;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;

   localparam logic [6:0] SENTENCE_MAX = 7'd80;
   localparam int unsigned QUEUE_DEPTH = 4;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } result_type;

   function automatic logic [7:0] header_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h47;
         3'd1: c = 8'h50;
         3'd2: c = 8'h52;
         3'd3: c = 8'h4D;
         3'd4: c = 8'h43;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/nmea_rmc_field_extractor_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_field_extractor_core
// Finds $GPRMC sentences in a byte stream and tags the bytes of each field.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle while full is low: the parser updates its
// header, comma and position counters on each byte that it takes, and every
// byte that yields a field kind is pushed into a QUEUE_DEPTH-entry result
// queue. full rises only when that queue holds QUEUE_DEPTH unread words; as
// long as pop keeps up, bytes flow in and results flow out at one word per
// cycle each, and rsp_field_kind is read from the registered queue memory.
// Setting link_failed discards every incoming byte; the parser hunts for '$'.
// ----------------------------------------------------------------------------
module nmea_rmc_field_extractor_core
   import nrmc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_field_kind,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic       link_failed_ff, link_failed_in;
   logic       accept;
   result_type res;

   assign pready = 1'b1;
   assign prdata = {31'd0, link_failed_ff};
   assign accept = push && !full;

   always_comb begin
      link_failed_in = link_failed_ff;
      if (psel && penable && pwrite && paddr == 2'd0) begin
         link_failed_in = pwdata[0];
      end else if (psel && penable && pwrite) begin
         link_failed_in = link_failed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_failed_ff <= 1'b0;
      end else begin
         link_failed_ff <= link_failed_in;
      end
   end

   nrmc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .link_failed (link_failed_ff),
      .res         (res)
   );

   nrmc_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (res),
      .pop     (pop),
      .empty   (empty),
      .full    (full),
      .rd_kind (rsp_field_kind)
   );

endmodule

// ----- rtl/nrmc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_front
// Sentence parser: hunts for the header, counts commas and tags field bytes.
// ----------------------------------------------------------------------------
module nrmc_front
   import nrmc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic       link_failed,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_HEAD = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] header_count_ff, header_count_in;
   logic       header_match_ff, header_match_in;
   logic [6:0] byte_count_ff, byte_count_in;
   logic [3:0] comma_count_ff, comma_count_in;
   logic [6:0] field_position_ff, field_position_in;

   logic       is_comma;
   logic       match_nx;
   logic [6:0] byte_count_nx;
   logic       tag_valid;
   kind_type   tag_kind;

   assign is_comma      = (rx_byte == CHAR_COMMA);
   assign match_nx      = header_match_ff & (rx_byte == header_char(header_count_ff));
   assign byte_count_nx = byte_count_ff + 7'd1;

   always_comb begin
      tag_valid = 1'b0;
      tag_kind  = KIND_TIME;
      if (comma_count_ff == 4'd3) begin
         tag_valid = 1'b1;
         tag_kind  = KIND_LAT;
      end else if (comma_count_ff == 4'd5) begin
         tag_valid = 1'b1;
         tag_kind  = KIND_LON;
      end else if (!is_comma) begin
         case (comma_count_ff)
            4'd1: begin
               tag_valid = (field_position_ff < 7'd6);
               tag_kind  = KIND_TIME;
            end
            4'd2: begin
               tag_valid = (field_position_ff == 7'd0);
               tag_kind  = KIND_STATUS;
            end
            4'd4: begin
               tag_valid = 1'b1;
               tag_kind  = KIND_LAT;
            end
            4'd6: begin
               tag_valid = 1'b1;
               tag_kind  = KIND_LON;
            end
            4'd7: begin
               tag_valid = 1'b1;
               tag_kind  = KIND_SPEED;
            end
            4'd9: begin
               tag_valid = (field_position_ff < 7'd6);
               tag_kind  = KIND_DATE;
            end
            default: begin
               tag_valid = 1'b0;
               tag_kind  = KIND_TIME;
            end
         endcase
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      header_count_in   = header_count_ff;
      header_match_in   = header_match_ff;
      byte_count_in     = byte_count_ff;
      comma_count_in    = comma_count_ff;
      field_position_in = field_position_ff;
      res               = '0;
      if (accept) begin
         if (link_failed) begin
            phase_in          = PH_HUNT;
            header_count_in   = 3'd0;
            header_match_in   = 1'b1;
            byte_count_in     = 7'd0;
            comma_count_in    = 4'd0;
            field_position_in = 7'd0;
         end else begin
            case (phase_ff)
               PH_HEAD: begin
                  header_count_in = header_count_ff + 3'd1;
                  header_match_in = match_nx;
                  byte_count_in   = byte_count_nx;
                  if (header_count_ff >= 3'd4) begin
                     if (match_nx) begin
                        phase_in          = PH_BODY;
                        comma_count_in    = 4'd0;
                        field_position_in = 7'd0;
                     end else begin
                        phase_in          = PH_HUNT;
                        header_count_in   = 3'd0;
                        header_match_in   = 1'b1;
                        byte_count_in     = 7'd0;
                        comma_count_in    = 4'd0;
                        field_position_in = 7'd0;
                     end
                  end
               end
               PH_BODY: begin
                  byte_count_in = byte_count_nx;
                  if (rx_byte == CHAR_STAR || byte_count_nx >= SENTENCE_MAX) begin
                     phase_in          = PH_HUNT;
                     header_count_in   = 3'd0;
                     header_match_in   = 1'b1;
                     byte_count_in     = 7'd0;
                     comma_count_in    = 4'd0;
                     field_position_in = 7'd0;
                     res.valid         = 1'b1;
                     res.kind          = (rx_byte == CHAR_STAR) ? KIND_END : KIND_ABORT;
                  end else begin
                     res.valid = tag_valid;
                     res.kind  = tag_kind;
                     if (is_comma) begin
                        if (comma_count_ff != 4'd15) begin
                           comma_count_in = comma_count_ff + 4'd1;
                        end
                        field_position_in = 7'd0;
                     end else if (field_position_ff != 7'd127) begin
                        field_position_in = field_position_ff + 7'd1;
                     end
                  end
               end
               default: begin
                  if (rx_byte == CHAR_DOLLAR) begin
                     phase_in          = PH_HEAD;
                     header_count_in   = 3'd0;
                     header_match_in   = 1'b1;
                     byte_count_in     = 7'd1;
                     comma_count_in    = 4'd0;
                     field_position_in = 7'd0;
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HUNT;
         header_count_ff   <= 3'd0;
         header_match_ff   <= 1'b1;
         byte_count_ff     <= 7'd0;
         comma_count_ff    <= 4'd0;
         field_position_ff <= 7'd0;
      end else begin
         phase_ff          <= phase_in;
         header_count_ff   <= header_count_in;
         header_match_ff   <= header_match_in;
         byte_count_ff     <= byte_count_in;
         comma_count_ff    <= comma_count_in;
         field_position_ff <= field_position_in;
      end
   end

   a_res_only_in_body: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (accept && !link_failed && phase_ff == PH_BODY))
      else $error("result word outside sentence body");

   a_link_fail_hunts: assert property (@(posedge clock) disable iff (reset)
      (accept && link_failed) |=> (phase_ff == PH_HUNT && byte_count_ff == 7'd0))
      else $error("parser not hunting after word on failed link");

   a_body_below_limit: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (byte_count_ff < SENTENCE_MAX))
      else $error("body byte count at or past sentence limit");

endmodule

// ----- rtl/nrmc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrmc_queue
// Short result queue between the parser and the result port.
// ----------------------------------------------------------------------------
module nrmc_queue
   import nrmc_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  result_type wr,
   input  logic       pop,
   output logic       empty,
   output logic       full,
   output kind_type   rd_kind
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   kind_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign rd_kind = mem_ff[rd_ptr_ff];
   assign do_wr   = wr.valid;
   assign do_rd   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_wr ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_rd ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr.kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !wr.valid)
      else $error("result word written into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count past depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule
